### sv/mse_pkg.sv
// Shared types, widths and register codes for the moving-sum echo detector.
package mse_pkg;

    localparam int SAMPLE_W          = 8;
    localparam int SAMPLES_PER_BLOCK = 8;
    localparam int TOTAL_W           = 11;
    localparam int SUM_W             = 17;
    localparam int SEEN_W            = 13;
    localparam int WIN_W             = 9;
    localparam int BUF_W             = 16;
    localparam int THR_W             = 8;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;

    localparam int MAX_WINDOW_BLOCKS_DEF = 32;

    localparam logic [WIN_W-1:0] WINDOW_LENGTH_RST   = 9'd64;
    localparam logic [BUF_W-1:0] BUFFER_LENGTH_RST   = 16'd1024;
    localparam logic [THR_W-1:0] LEVEL_THRESHOLD_RST = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH   = 2'd0,
        REG_BUFFER_LENGTH   = 2'd1,
        REG_LEVEL_THRESHOLD = 2'd2
    } cfg_reg_t;

    // Control for the slot counter bank, one entry per processed beat.
    typedef struct packed {
        logic step;
        logic restart;
        logic wrap;
    } bank_ctl_t;

endpackage

### sv/mse_history.sv
// Block-total history memory: one write port, one registered read port with write bypass.
module mse_history
    import mse_pkg::*;
#(
    parameter int DEPTH  = MAX_WINDOW_BLOCKS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [TOTAL_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [TOTAL_W-1:0] rd_data
);

    logic [TOTAL_W-1:0] mem [DEPTH];
    logic [TOTAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Forward a same-edge write so the reader sees the newest total.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/mse_slot_bank.sv
// Bank of counters, counter j holding the block count modulo j+1.
module mse_slot_bank
    import mse_pkg::*;
#(
    parameter int NUM   = MAX_WINDOW_BLOCKS_DEF,
    parameter int IDX_W = (NUM > 1) ? $clog2(NUM) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  bank_ctl_t        ctl,
    input  logic [IDX_W-1:0] sel,
    output logic [IDX_W-1:0] slot_ahead
);

    logic [IDX_W-1:0] cnt_reg  [NUM];
    logic [IDX_W-1:0] cnt_next [NUM];

    for (genvar j = 0; j < NUM; j++)
    begin : g_cnt
        logic [IDX_W-1:0] base;

        always_comb
        begin
            base        = ctl.restart ? '0 : cnt_reg[j];
            cnt_next[j] = cnt_reg[j];
            if (ctl.step)
            begin
                if (ctl.wrap || (base == IDX_W'(j)))
                begin
                    cnt_next[j] = '0;
                end
                else
                begin
                    cnt_next[j] = base + 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[j] <= '0;
            end
            else
            begin
                cnt_reg[j] <= cnt_next[j];
            end
        end
    end

    // Slot as it stands after this edge, for the window size in force.
    assign slot_ahead = cnt_next[sel];

endmodule

### sv/moving_sum_echo_detector.sv
// Top level of the moving-sum echo detector.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | in        | in_valid / in_stall  | sample_0..sample_7, buffer_start
//  out     | out       | out_valid / out_stall| echo_index, echo_found
//  cfg     | in        | cfg_write            | cfg_index, cfg_data (no read-back)
//
// One block beat per cycle sustained while in_stall is low; a result reaches the out
// channel through the input stage and then the result register. The window sum closes
// on itself in the compute stage, which sets the rate.
// Reset clears the sum, block count and slot counters and marks the block as
// decided, so beats are dropped until one carries buffer_start.
// in_stall rises only when a deciding beat waits behind a result held by out_stall.
module moving_sum_echo_detector
    import mse_pkg::*;
#(
    parameter int MAX_WINDOW_BLOCKS = MAX_WINDOW_BLOCKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SAMPLE_W-1:0]   sample_0,
    input  logic [SAMPLE_W-1:0]   sample_1,
    input  logic [SAMPLE_W-1:0]   sample_2,
    input  logic [SAMPLE_W-1:0]   sample_3,
    input  logic [SAMPLE_W-1:0]   sample_4,
    input  logic [SAMPLE_W-1:0]   sample_5,
    input  logic [SAMPLE_W-1:0]   sample_6,
    input  logic [SAMPLE_W-1:0]   sample_7,
    input  logic                  buffer_start,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BUF_W-1:0]      echo_index,
    output logic                  echo_found,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_WINDOW_BLOCKS > 1) ? $clog2(MAX_WINDOW_BLOCKS) : 1;
    localparam logic [WIN_W-1:0] MAX_BLOCKS_W = WIN_W'(MAX_WINDOW_BLOCKS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIN_W-1:0] window_length_reg;
    logic [BUF_W-1:0] buffer_length_reg;
    logic [THR_W-1:0] level_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg   <= WINDOW_LENGTH_RST;
            buffer_length_reg   <= BUFFER_LENGTH_RST;
            level_threshold_reg <= LEVEL_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WINDOW_LENGTH:   window_length_reg   <= cfg_data[WIN_W-1:0];
                REG_BUFFER_LENGTH:   buffer_length_reg   <= cfg_data[BUF_W-1:0];
                REG_LEVEL_THRESHOLD: level_threshold_reg <= cfg_data[THR_W-1:0];
                default:             ;
            endcase
        end
    end

    // Window in blocks, clamped to the history depth.
    logic [WIN_W-1:0] win_blocks_raw;
    logic [WIN_W-1:0] win_blocks;
    logic [IDX_W-1:0] bank_sel;

    assign win_blocks_raw = {3'b000, window_length_reg[WIN_W-1:3]};
    assign win_blocks     = (win_blocks_raw > MAX_BLOCKS_W) ? MAX_BLOCKS_W : win_blocks_raw;
    assign bank_sel       = (win_blocks == '0) ? '0 : IDX_W'(win_blocks - 1'b1);

    // ------------------------------------------------------------------
    // Input stage: sum the eight samples, capture start and history slot
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] samples [SAMPLES_PER_BLOCK];
    logic [TOTAL_W-1:0]  in_total;

    assign samples[0] = sample_0;
    assign samples[1] = sample_1;
    assign samples[2] = sample_2;
    assign samples[3] = sample_3;
    assign samples[4] = sample_4;
    assign samples[5] = sample_5;
    assign samples[6] = sample_6;
    assign samples[7] = sample_7;

    always_comb
    begin
        in_total = '0;
        for (int i = 0; i < SAMPLES_PER_BLOCK; i++)
        begin
            in_total = in_total + TOTAL_W'(samples[i]);
        end
    end

    logic               st_valid_reg;
    logic               st_valid_next;
    logic [TOTAL_W-1:0] st_total_reg;
    logic               st_start_reg;
    logic [IDX_W-1:0]   st_slot_reg;

    logic               accept;
    logic               fire;
    logic [IDX_W-1:0]   slot_ahead;
    logic [IDX_W-1:0]   rd_addr;
    logic [TOTAL_W-1:0] old_total;

    assign in_stall = st_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;
    // A start beat always lands in slot zero.
    assign rd_addr  = buffer_start ? '0 : slot_ahead;

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (accept)
        begin
            st_valid_next = 1'b1;
        end
        else if (fire)
        begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_total_reg <= in_total;
            st_start_reg <= buffer_start;
            st_slot_reg  <= rd_addr;
        end
    end

    // ------------------------------------------------------------------
    // Compute stage: update window sum, decide
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  window_sum_reg;
    logic [SUM_W-1:0]  window_sum_next;
    logic [SEEN_W-1:0] blocks_seen_reg;
    logic [SEEN_W-1:0] blocks_seen_next;
    logic              decided_reg;
    logic              decided_next;

    logic [SUM_W-1:0]  eff_sum;
    logic [SEEN_W-1:0] eff_seen;
    logic              live;
    logic [SEEN_W-1:0] win_seen;
    logic              in_fill;
    logic [SUM_W-1:0]  new_sum;
    logic [SUM_W-1:0]  target;
    logic [BUF_W-1:0]  buf_minus_win;
    logic [SEEN_W-1:0] slide_steps;
    logic [SEEN_W-1:0] slide_k;
    logic [SEEN_W-1:0] remaining;
    logic              emit;
    logic [BUF_W-1:0]  emit_index;
    logic              emit_found;
    logic              out_free;
    bank_ctl_t         bank_ctl;

    // A start beat sees a cleared sum, count and decision.
    assign eff_sum  = st_start_reg ? '0 : window_sum_reg;
    assign eff_seen = st_start_reg ? '0 : blocks_seen_reg;
    assign live     = st_start_reg || !decided_reg;

    assign win_seen = SEEN_W'(win_blocks);
    assign in_fill  = eff_seen < win_seen;
    assign target   = SUM_W'(level_threshold_reg) * SUM_W'(window_length_reg);

    assign buf_minus_win = buffer_length_reg - BUF_W'(window_length_reg);
    assign slide_steps   = (buffer_length_reg >= BUF_W'(window_length_reg)) ?
                           buf_minus_win[BUF_W-1:3] : '0;
    assign slide_k       = eff_seen - win_seen;
    assign remaining     = (slide_k < slide_steps) ? (slide_steps - slide_k) : '0;

    always_comb
    begin
        if (in_fill)
        begin
            new_sum = eff_sum + SUM_W'(st_total_reg);
        end
        else
        begin
            new_sum = eff_sum + SUM_W'(st_total_reg) - SUM_W'(old_total);
        end
    end

    always_comb
    begin
        emit       = 1'b0;
        emit_index = '0;
        emit_found = 1'b0;
        if (win_blocks == '0)
        begin
            emit = 1'b1;
        end
        else if (in_fill)
        begin
            if (eff_seen == (win_seen - 1'b1))
            begin
                if (new_sum > target)
                begin
                    emit       = 1'b1;
                    emit_index = BUF_W'(1);
                    emit_found = 1'b1;
                end
                else if (slide_steps == '0)
                begin
                    emit = 1'b1;
                end
            end
        end
        else
        begin
            if (new_sum > target)
            begin
                emit       = 1'b1;
                emit_index = buffer_length_reg - {remaining, 3'b000};
                emit_found = 1'b1;
            end
            else if (remaining <= SEEN_W'(1))
            begin
                emit = 1'b1;
            end
        end
    end

    // Non-deciding beats pass even while the result register is held.
    assign out_free = !out_valid || !out_stall;
    assign fire     = st_valid_reg && (out_free || !(live && emit));

    always_comb
    begin
        window_sum_next  = window_sum_reg;
        blocks_seen_next = blocks_seen_reg;
        decided_next     = decided_reg;
        if (fire && live)
        begin
            blocks_seen_next = eff_seen + 1'b1;
            window_sum_next  = (win_blocks == '0) ? eff_sum : new_sum;
            decided_next     = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_sum_reg  <= '0;
            blocks_seen_reg <= '0;
            decided_reg     <= 1'b1;
        end
        else
        begin
            window_sum_reg  <= window_sum_next;
            blocks_seen_reg <= blocks_seen_next;
            decided_reg     <= decided_next;
        end
    end

    // Advance the slot counters with the block count.
    assign bank_ctl.step    = fire && live;
    assign bank_ctl.restart = st_start_reg;
    assign bank_ctl.wrap    = (eff_seen == '1);

    mse_slot_bank #(
        .NUM   (MAX_WINDOW_BLOCKS),
        .IDX_W (IDX_W)
    ) u_slot_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (bank_ctl),
        .sel        (bank_sel),
        .slot_ahead (slot_ahead)
    );

    // History write: store this beat's total over the slot it retires.
    mse_history #(
        .DEPTH  (MAX_WINDOW_BLOCKS),
        .ADDR_W (IDX_W)
    ) u_history (
        .clk     (clk),
        .wr_en   (fire && live && (win_blocks != '0)),
        .wr_addr (st_slot_reg),
        .wr_data (st_total_reg),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (old_total)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [BUF_W-1:0] echo_index_reg;
    logic             echo_found_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && live && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && live && emit)
        begin
            echo_index_reg <= emit_index;
            echo_found_reg <= emit_found;
        end
    end

    assign out_valid  = out_valid_reg;
    assign echo_index = echo_index_reg;
    assign echo_found = echo_found_reg;

endmodule

### sv/mse_checker.sv
// Port-level checker for the moving-sum echo detector, bound to the top level.
module mse_checker
    import mse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample_0,
    input  logic                buffer_start,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [BUF_W-1:0]    echo_index,
    input  logic                echo_found
);

    // Input backs up only behind a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a held result");

    // A miss always reports position zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !echo_found) |-> (echo_index == '0))
        else $error("miss with nonzero echo_index");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(echo_index) && $stable(echo_found)))
        else $error("held result changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=>
            (in_valid && $stable(sample_0) && $stable(buffer_start)))
        else $error("held input beat changed");

endmodule

bind moving_sum_echo_detector mse_checker u_mse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_0     (sample_0),
    .buffer_start (buffer_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .echo_index   (echo_index),
    .echo_found   (echo_found)
);

### test/moving_sum_echo_detector_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the moving-sum echo detector: directed table, then random buffers.
module moving_sum_echo_detector_tb;
    import mse_pkg::*;

    localparam int HIST_DEPTH      = MAX_WINDOW_BLOCKS_DEF;
    localparam int SETTLE_CYCLES   = 8;     // input stage plus result register, with margin
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int BEATS_PER_MODE  = 220;
    localparam int MAX_GAP         = 12;

    localparam logic [63:0] FULL_BLOCK  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] QUIET_BLOCK = 64'h0;

    typedef enum logic [1:0] {ROW_CFG, ROW_BEAT} row_kind_t;
    // How a directed row is checked: by the predictor, against a hand-typed result, or not at all.
    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_RESULT} row_check_t;

    typedef struct packed {
        logic [BUF_W-1:0] idx;
        logic             found;
    } echo_t;

    typedef struct packed {
        row_kind_t              kind;
        cfg_reg_t               sel;
        logic [CFG_DATA_W-1:0]  value;
        logic [63:0]            blk;
        logic                   start;
        row_check_t             chk;
        echo_t                  res;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample_0 = '0;
    logic [SAMPLE_W-1:0]   sample_1 = '0;
    logic [SAMPLE_W-1:0]   sample_2 = '0;
    logic [SAMPLE_W-1:0]   sample_3 = '0;
    logic [SAMPLE_W-1:0]   sample_4 = '0;
    logic [SAMPLE_W-1:0]   sample_5 = '0;
    logic [SAMPLE_W-1:0]   sample_6 = '0;
    logic [SAMPLE_W-1:0]   sample_7 = '0;
    logic                  buffer_start = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [BUF_W-1:0]      echo_index;
    logic                  echo_found;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: window ring, running sum, block count and the decided flag.
    logic [63:0]      hist_blocks [HIST_DEPTH];
    logic [SUM_W-1:0] win_sum;
    logic [SEEN_W-1:0] blk_count;
    logic             buf_done;
    logic [WIN_W-1:0] cur_window;
    logic [BUF_W-1:0] cur_buffer;
    logic [THR_W-1:0] cur_level;

    echo_t     pending_echoes [$];
    plan_row_t directed_plan [$];

    int error_count  = 0;
    int scored_beats = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_tickets = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    moving_sum_echo_detector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_0     (sample_0),
        .sample_1     (sample_1),
        .sample_2     (sample_2),
        .sample_3     (sample_3),
        .sample_4     (sample_4),
        .sample_5     (sample_5),
        .sample_6     (sample_6),
        .sample_7     (sample_7),
        .buffer_start (buffer_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .echo_index   (echo_index),
        .echo_found   (echo_found),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 50)
            $display("%0t: %s", $time, what);
    endtask

    // Sum the eight unsigned samples packed into one block.
    function automatic int unsigned block_level(input logic [63:0] blk);
        int unsigned total;
        total = 0;
        for (int i = 0; i < SAMPLES_PER_BLOCK; i++)
            total += blk[8*i +: 8];
        return total;
    endfunction

    // Advance the predictor by one accepted beat. counted is low when the beat is dropped
    // because the buffer is already decided; fired is high when the beat yields a result.
    function automatic void predict_echo(input logic [63:0] blk, input logic start,
                                         output logic fired, output echo_t res,
                                         output logic counted);
        int unsigned w, s, target, b, slot, nsum, k, rem, wl, bl;
        logic [31:0] acc;
        fired   = 1'b0;
        res     = '0;
        counted = 1'b0;
        if (start)
        begin
            win_sum   = '0;
            blk_count = '0;
            buf_done  = 1'b0;
        end
        if (buf_done)
            return;
        counted = 1'b1;
        wl     = cur_window;
        bl     = cur_buffer;
        nsum   = block_level(blk);
        w      = wl >> 3;
        if (w > HIST_DEPTH)
            w = HIST_DEPTH;
        s      = (bl >= wl) ? ((bl - wl) >> 3) : 0;
        target = cur_level * wl;
        b      = blk_count;
        blk_count = blk_count + 1'b1;
        if (w == 0)
            fired = 1'b1;
        else
        begin
            slot = b % w;
            if (b < w)
            begin
                // still filling the window
                hist_blocks[slot] = blk;
                acc     = win_sum + nsum;
                win_sum = acc[SUM_W-1:0];
                if (b == w - 1)
                begin
                    if (win_sum > target)
                    begin
                        fired     = 1'b1;
                        res.idx   = BUF_W'(1);
                        res.found = 1'b1;
                    end
                    else if (s == 0)
                        fired = 1'b1;
                end
            end
            else
            begin
                // slide: drop the oldest block, add the new one
                k   = b - w;
                rem = (k < s) ? (s - k) : 0;
                acc = win_sum + nsum - block_level(hist_blocks[slot]);
                win_sum = acc[SUM_W-1:0];
                hist_blocks[slot] = blk;
                if (win_sum > target)
                begin
                    acc       = bl - (rem << 3);
                    fired     = 1'b1;
                    res.idx   = acc[BUF_W-1:0];
                    res.found = 1'b1;
                end
                else if (rem <= 1)
                    fired = 1'b1;
            end
        end
        if (fired)
            buf_done = 1'b1;
    endfunction

    // Offer one beat, hold it until accepted, then queue what the block should answer.
    task automatic drive_beat(input logic [63:0] blk, input logic start,
                              input row_check_t chk, input echo_t typed);
        int    gap;
        logic  fired;
        logic  counted;
        echo_t res;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        sample_0     <= blk[7:0];
        sample_1     <= blk[15:8];
        sample_2     <= blk[23:16];
        sample_3     <= blk[31:24];
        sample_4     <= blk[39:32];
        sample_5     <= blk[47:40];
        sample_6     <= blk[55:48];
        sample_7     <= blk[63:56];
        buffer_start <= start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_echo(blk, start, fired, res, counted);
        if (counted)
            scored_beats++;
        case (chk)
            CHK_PREDICT:
            begin
                if (fired)
                    pending_echoes.push_back(res);
            end
            CHK_RESULT: pending_echoes.push_back(typed);
            default: ;
        endcase
    endtask

    // Drop valid, wait for every queued result, then let the pipeline settle.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_echoes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (sel)
            REG_WINDOW_LENGTH:   cur_window = value[WIN_W-1:0];
            REG_BUFFER_LENGTH:   cur_buffer = value[BUF_W-1:0];
            REG_LEVEL_THRESHOLD: cur_level  = value[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int win, input int buf_len, input int lvl);
        wait_drained();
        write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(win));
        write_reg(REG_BUFFER_LENGTH, CFG_DATA_W'(buf_len));
        write_reg(REG_LEVEL_THRESHOLD, CFG_DATA_W'(lvl));
    endtask

    function automatic void add_cfg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        plan_row_t row;
        row       = '0;
        row.kind  = ROW_CFG;
        row.sel   = sel;
        row.value = value;
        directed_plan.push_back(row);
    endfunction

    function automatic void add_beat(input logic [63:0] blk, input logic start,
                                     input row_check_t chk, input int idx, input logic found);
        plan_row_t row;
        row           = '0;
        row.kind      = ROW_BEAT;
        row.blk       = blk;
        row.start     = start;
        row.chk       = chk;
        row.res.idx   = BUF_W'(idx);
        row.res.found = found;
        directed_plan.push_back(row);
    endfunction

    // Quiet samples stay at or below the level, loud ones at or above it; a few
    // blocks are extremes or fully random so every sample bit moves.
    function automatic logic [63:0] make_block(input logic loud);
        logic [63:0] blk;
        int unsigned pick;
        pick = $urandom_range(15);
        if (pick == 0)
            return FULL_BLOCK;
        if (pick == 1)
            return QUIET_BLOCK;
        if (pick <= 3)
            return {$urandom, $urandom};
        for (int i = 0; i < SAMPLES_PER_BLOCK; i++)
            blk[8*i +: 8] = loud ? SAMPLE_W'($urandom_range(255, cur_level))
                                 : SAMPLE_W'($urandom_range(cur_level, 0));
        return blk;
    endfunction

    // Run one buffer to its decision. A negative echo_at picks the loud onset at random.
    task automatic run_buffer(input int echo_at, input logic allow_restart);
        int          w;
        int          s;
        int          onset;
        int          n;
        logic        start;
        logic [63:0] blk;
        w = cur_window >> 3;
        if (w > HIST_DEPTH)
            w = HIST_DEPTH;
        s = (cur_buffer >= cur_window) ? ((cur_buffer - cur_window) >> 3) : 0;
        onset = (echo_at < 0) ? $urandom_range(w + s + 1, 0) : echo_at;
        n     = 0;
        start = 1'b1;
        while (start || !buf_done)
        begin
            blk = make_block(n >= onset);
            // occasionally break the buffer off and begin a new one
            if (!start && allow_restart && $urandom_range(31) == 0)
                start = 1'b1;
            drive_beat(blk, start, CHK_PREDICT, '0);
            start = 1'b0;
            n++;
        end
        // stray beats after the decision are dropped by the block
        repeat ($urandom_range(2))
            drive_beat({$urandom, $urandom}, 1'b0, CHK_PREDICT, '0);
    endtask

    task automatic pick_config(input int round);
        int win;
        int buf_len;
        int pick;
        case (round)
            0: set_config(8, 8, 0);          // one-block window, no slide
            1: set_config(511, 600, 255);    // window clamped, target out of reach
            2: set_config(5, 1000, 100);     // window under one block
            3: set_config(12, 20, 255);      // odd window, one slide block
            4: set_config(100, 40, 50);      // buffer shorter than window
            5: set_config(256, 300, 200);    // full history
            default:
            begin
                pick = $urandom_range(19);
                if (pick < 14)
                    win = $urandom_range(64, 8);
                else if (pick < 18)
                    win = $urandom_range(256, 65);
                else if (pick == 18)
                    win = $urandom_range(7, 0);
                else
                    win = $urandom_range(511, 257);
                if ($urandom_range(3) == 0)
                    buf_len = $urandom_range(win + 8, 8);
                else
                    buf_len = win + $urandom_range(240, 0);
                set_config(win, buf_len, $urandom_range(255));
            end
        endcase
    endtask

    // Receiver: random stall per cycle, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_served != hold_tickets)
        begin
            hold_served = hold_tickets;
            hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        echo_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_echoes.size() == 0)
                report_mismatch($sformatf("unexpected result: index %0d found %0b",
                                          echo_index, echo_found));
            else
            begin
                want = pending_echoes.pop_front();
                if (echo_index !== want.idx)
                    report_mismatch($sformatf("echo_index %0d, expected %0d",
                                              echo_index, want.idx));
                if (echo_found !== want.found)
                    report_mismatch($sformatf("echo_found %0b, expected %0b",
                                              echo_found, want.found));
            end
        end
    end

    initial
    begin
        int round;
        int mode_start;

        // predictor starts from the reset state: decided, default registers
        for (int i = 0; i < HIST_DEPTH; i++)
            hist_blocks[i] = '0;
        win_sum    = '0;
        blk_count  = '0;
        buf_done   = 1'b1;
        cur_window = WINDOW_LENGTH_RST;
        cur_buffer = BUFFER_LENGTH_RST;
        cur_level  = LEVEL_THRESHOLD_RST;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. Reset registers: window 64, buffer 1024, level 16.
        add_beat(FULL_BLOCK, 1'b0, CHK_NONE, 0, 1'b0);      // no start seen yet: dropped
        add_cfg(REG_WINDOW_LENGTH, 4);
        add_beat(FULL_BLOCK, 1'b1, CHK_RESULT, 0, 1'b0);    // window under one block
        add_beat(FULL_BLOCK, 1'b0, CHK_NONE, 0, 1'b0);      // after decision: dropped
        add_cfg(REG_WINDOW_LENGTH, 16);
        add_cfg(REG_BUFFER_LENGTH, 16);
        add_cfg(REG_LEVEL_THRESHOLD, 255);
        add_beat(FULL_BLOCK, 1'b1, CHK_NONE, 0, 1'b0);
        add_beat(FULL_BLOCK, 1'b0, CHK_RESULT, 0, 1'b0);    // sum equals target: no crossing
        add_cfg(REG_LEVEL_THRESHOLD, 0);
        add_beat(QUIET_BLOCK, 1'b1, CHK_NONE, 0, 1'b0);
        add_beat(QUIET_BLOCK, 1'b0, CHK_RESULT, 0, 1'b0);
        add_beat(64'h0100_0000_0000_0000, 1'b1, CHK_NONE, 0, 1'b0);
        add_beat(QUIET_BLOCK, 1'b0, CHK_RESULT, 1, 1'b1);   // crossing on first fill
        add_cfg(REG_BUFFER_LENGTH, 48);
        add_cfg(REG_LEVEL_THRESHOLD, 1);
        add_beat(QUIET_BLOCK, 1'b1, CHK_NONE, 0, 1'b0);
        add_beat(QUIET_BLOCK, 1'b0, CHK_NONE, 0, 1'b0);
        add_beat(QUIET_BLOCK, 1'b0, CHK_NONE, 0, 1'b0);
        add_beat(FULL_BLOCK, 1'b0, CHK_RESULT, 24, 1'b1);   // crossing on second slide
        add_beat(QUIET_BLOCK, 1'b1, CHK_NONE, 0, 1'b0);
        add_beat(QUIET_BLOCK, 1'b0, CHK_NONE, 0, 1'b0);
        add_beat(FULL_BLOCK, 1'b1, CHK_NONE, 0, 1'b0);      // restart inside a buffer
        add_beat(QUIET_BLOCK, 1'b0, CHK_RESULT, 1, 1'b1);
        add_beat(QUIET_BLOCK, 1'b1, CHK_NONE, 0, 1'b0);
        add_beat(QUIET_BLOCK, 1'b0, CHK_NONE, 0, 1'b0);
        add_beat(64'h10, 1'b0, CHK_PREDICT, 0, 1'b0);       // window sum right at target
        add_beat(QUIET_BLOCK, 1'b0, CHK_PREDICT, 0, 1'b0);
        add_beat(QUIET_BLOCK, 1'b0, CHK_PREDICT, 0, 1'b0);
        add_beat(QUIET_BLOCK, 1'b0, CHK_RESULT, 0, 1'b0);   // last slide, no crossing
        add_cfg(REG_BUFFER_LENGTH, 8);
        add_beat(FULL_BLOCK, 1'b1, CHK_NONE, 0, 1'b0);      // buffer shorter than window
        add_beat(QUIET_BLOCK, 1'b0, CHK_RESULT, 1, 1'b1);

        tx_idle_pct = 16;
        rx_idle_pct = 54;
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(directed_plan[i].sel, directed_plan[i].value);
            end
            else
                drive_beat(directed_plan[i].blk, directed_plan[i].start,
                           directed_plan[i].chk, directed_plan[i].res);
        end

        // Random buffers under three idle mixes.
        round = 0;
        for (int mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 54 : 0;
            rx_idle_pct = (mode == 0) ? 54 : (mode == 1) ? 16 : 0;
            if (mode == 2)
            begin
                // every start beat decides; hold the receiver so the block backs up
                set_config(4, 64, 9);
                hold_tickets++;
                repeat (40)
                    drive_beat(make_block(1'b1), 1'b1, CHK_PREDICT, '0);
                // one full-size buffer, crossing on an early slide at index 335
                set_config(256, 65535, 0);
                drive_beat(QUIET_BLOCK, 1'b1, CHK_PREDICT, '0);
                repeat (40)
                    drive_beat(QUIET_BLOCK, 1'b0, CHK_PREDICT, '0);
                drive_beat(FULL_BLOCK, 1'b0, CHK_PREDICT, '0);
                run_buffer(0, 1'b0);
            end
            mode_start = scored_beats;
            while (scored_beats - mode_start < BEATS_PER_MODE)
            begin
                pick_config(round);
                round++;
                repeat ($urandom_range(4, 1))
                    run_buffer(-1, 1'b1);
            end
        end

        wait_drained();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
sv/mse_pkg.sv
sv/mse_history.sv
sv/mse_slot_bank.sv
sv/moving_sum_echo_detector.sv
sv/mse_checker.sv
test/moving_sum_echo_detector_tb.sv
